@@ hdl/double_precision_pack_round_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the double precision pack and round unit
// Clocked, reset-qualified implication checks shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_PRECISION_PACK_ROUND_UNIT_DEFINES_SVH
`define DOUBLE_PRECISION_PACK_ROUND_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/dppr_pkg.sv @@
// ----------------------------------------------------------------------------
// dppr_pkg
// Types and constants for the binary64 pack and round pipeline.
// ----------------------------------------------------------------------------
package dppr_pkg;

    // input class codes
    localparam logic [1:0] CLS_FINITE = 2'd0;
    localparam logic [1:0] CLS_ZERO   = 2'd1;
    localparam logic [1:0] CLS_INF    = 2'd2;
    localparam logic [1:0] CLS_NAN    = 2'd3;

    localparam int unsigned EXP_W  = 11;
    localparam int unsigned FRAC_W = 52;
    localparam int unsigned SIG_W  = 64;
    localparam int unsigned SHAMT_W = 6;

    localparam logic signed [31:0] EXP_MIN_NORMAL = -32'sd1022;
    localparam logic signed [31:0] EXP_OVERFLOW   = 32'sd1024;
    localparam logic signed [32:0] MAX_SUB_SHIFT  = 33'sd56;

    localparam logic [EXP_W-1:0] EXP_BIAS     = 11'h3ff;
    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7ff;

    localparam logic [7:0] GUARD_HALF = 8'h80;
    localparam logic [7:0] GUARD_INC  = 8'h7f;

    // what the back end of the pipe has to do with an item
    typedef enum logic [2:0] {
        PK_ZERO,
        PK_INF,
        PK_NAN,
        PK_NORM,
        PK_SUB
    } pack_kind_t;

endpackage

@@ hdl/double_precision_pack_round_unit.sv @@
// ----------------------------------------------------------------------------
// double_precision_pack_round_unit
// Packs an unpacked double into IEEE-754 binary64, round to nearest even.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction accepted per cycle while in_stall is low;
// the result passes the decode, subnormal shift, and round and pack stages,
// each stage a register. Throughput is one result per cycle while out_stall
// is low; stalls on the output only back up the pipe, and empty stages are
// filled even while the output stalls, so in_stall rises only when all three
// stages hold a transaction. There is no kept state between transactions.
//
// Stage 1 classifies the operand: NaN, infinity, zero (class zero, zero
// significand, or an exponent so small the shift would exceed 56 bits),
// overflow to infinity (exponent of 1024 or more), subnormal, or normal.
// Stage 2 performs the subnormal right shift, folding shifted-out ones into
// bit 0 as a sticky bit. Stage 3 rounds on the 8 guard bits (ties to even),
// renormalizes on carry-out and assembles the two output words.
// ----------------------------------------------------------------------------
`include "double_precision_pack_round_unit_defines.svh"

module double_precision_pack_round_unit
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         value_class,
    input  logic               sign_bit,
    input  logic signed [31:0] unbiased_exponent,
    input  logic [63:0]        significand,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        packed_upper,
    output logic [31:0]        packed_lower
);
    import dppr_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline advance: a stage loads when it is empty or the next one
    // loads. Bubbles collapse, so nothing is dropped or duplicated.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic adv1, adv2, adv3;

    assign adv3     = !s3_valid_reg || !out_stall;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;

    // ------------------------------------------------------------------
    // Stage 1: classify, compute biased exponent and subnormal shift
    // ------------------------------------------------------------------
    pack_kind_t          s1_kind_reg, s1_kind_next;
    logic                s1_sign_reg;
    logic [EXP_W-1:0]    s1_biased_reg, s1_biased_next;
    logic [SHAMT_W-1:0]  s1_shamt_reg, s1_shamt_next;
    logic [SIG_W-1:0]    s1_sig_reg;

    logic signed [32:0]  sub_dist;

    always_comb
    begin
        sub_dist       = 33'(EXP_MIN_NORMAL) - {unbiased_exponent[31], unbiased_exponent};
        s1_kind_next   = PK_ZERO;
        s1_biased_next = unbiased_exponent[EXP_W-1:0] + EXP_BIAS;
        s1_shamt_next  = '0;
        case (value_class)
            CLS_NAN:  s1_kind_next = PK_NAN;
            CLS_INF:  s1_kind_next = PK_INF;
            CLS_ZERO: s1_kind_next = PK_ZERO;
            CLS_FINITE:
            begin
                if (significand == '0)
                    s1_kind_next = PK_ZERO;
                else if (unbiased_exponent >= EXP_OVERFLOW)
                    s1_kind_next = PK_INF;
                else if (unbiased_exponent < EXP_MIN_NORMAL)
                begin
                    // beyond 56 bits the rounded result is zero anyway
                    if (sub_dist > MAX_SUB_SHIFT)
                        s1_kind_next = PK_ZERO;
                    else
                    begin
                        s1_kind_next  = PK_SUB;
                        s1_shamt_next = sub_dist[SHAMT_W-1:0];
                    end
                end
                else
                    s1_kind_next = PK_NORM;
            end
            default:  s1_kind_next = PK_ZERO;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_kind_reg   <= s1_kind_next;
            s1_sign_reg   <= sign_bit;
            s1_biased_reg <= s1_biased_next;
            s1_shamt_reg  <= s1_shamt_next;
            s1_sig_reg    <= significand;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sticky right shift (zero shift for all but subnormals)
    // ------------------------------------------------------------------
    pack_kind_t          s2_kind_reg;
    logic                s2_sign_reg;
    logic [EXP_W-1:0]    s2_biased_reg;
    logic [SIG_W-1:0]    s2_sig_reg, s2_sig_next;

    logic [SIG_W-1:0]    shift_mask;
    logic                sticky;

    always_comb
    begin
        shift_mask  = (64'd1 << s1_shamt_reg) - 64'd1;
        sticky      = |(s1_sig_reg & shift_mask);
        s2_sig_next = (s1_sig_reg >> s1_shamt_reg) | {63'd0, sticky};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_kind_reg   <= s1_kind_reg;
            s2_sign_reg   <= s1_sign_reg;
            s2_biased_reg <= s1_biased_reg;
            s2_sig_reg    <= s2_sig_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round to nearest even on guard bits, renormalize, pack
    // ------------------------------------------------------------------
    pack_kind_t          s3_kind_reg;
    logic [31:0]         s3_upper_reg, s3_upper_next;
    logic [31:0]         s3_lower_reg, s3_lower_next;

    logic [SIG_W-1:0]    round_inc;
    logic [SIG_W-1:0]    rounded;
    logic [EXP_W-1:0]    exp_field;
    logic [FRAC_W-1:0]   frac_field;

    always_comb
    begin
        if (s2_sig_reg[7:0] == GUARD_HALF)
            round_inc = s2_sig_reg[8] ? {56'd0, GUARD_HALF} : '0;
        else
            round_inc = {56'd0, GUARD_INC};
        rounded    = s2_sig_reg + round_inc;
        exp_field  = '0;
        frac_field = '0;
        case (s2_kind_reg)
            PK_NAN:
            begin
                exp_field  = EXP_ALL_ONES;
                frac_field = s2_sig_reg[FRAC_W-1:0];
                frac_field[FRAC_W-1] = 1'b1;   // quiet
            end
            PK_INF:  exp_field = EXP_ALL_ONES;
            PK_ZERO: exp_field = '0;
            PK_SUB:
            begin
                exp_field  = (rounded[63:60] != 4'd0) ? 11'd1 : 11'd0;
                frac_field = rounded[59:8];
            end
            PK_NORM:
            begin
                if (rounded[63:61] != 3'd0)
                begin
                    exp_field  = s2_biased_reg + 11'd1;
                    frac_field = rounded[60:9];
                end
                else
                begin
                    exp_field  = s2_biased_reg;
                    frac_field = rounded[59:8];
                end
            end
            default: exp_field = '0;
        endcase
        s3_upper_next = {s2_sign_reg, exp_field, frac_field[FRAC_W-1:32]};
        s3_lower_next = frac_field[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            s3_kind_reg  <= s2_kind_reg;
            s3_upper_reg <= s3_upper_next;
            s3_lower_reg <= s3_lower_next;
        end
    end

    assign out_valid    = s3_valid_reg;
    assign packed_upper = s3_upper_reg;
    assign packed_lower = s3_lower_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `DPPR_ASSERT_NOW(a_stall_only_full, clk, rst_n, in_stall,
        s1_valid_reg && s2_valid_reg && s3_valid_reg,
        "input stalled while pipeline has a free stage")

    `DPPR_ASSERT_NEXT(a_s2_held, clk, rst_n,
        s2_valid_reg && s3_valid_reg && out_stall,
        s2_valid_reg, "stage 2 transaction lost under output stall")

    `DPPR_ASSERT_NOW(a_nan_quiet, clk, rst_n,
        s3_valid_reg && (s3_kind_reg == PK_NAN),
        packed_upper[30:19] == 12'hfff, "NaN result not quiet")

    `DPPR_ASSERT_NOW(a_sub_exp, clk, rst_n,
        s3_valid_reg && (s3_kind_reg == PK_SUB),
        packed_upper[30:21] == 10'd0, "subnormal result exponent above one")

endmodule
